>>> src/rast_pkg.sv
// Package for the range add / assign / sum tree block.
// Holds the node entry type, command codes, controller states and the
// command and status structs shared by the controller and the datapath.
`default_nettype none

package rast_pkg;

  localparam int CMD_W  = 2;
  localparam int POS_W  = 11;
  localparam int VAL_W  = 64;
  localparam int NODE_W = 3 * VAL_W + 1;

  localparam logic [POS_W-1:0] LEN_RESET = 11'd1024;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SUM    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // One tree node as stored in memory.
  typedef struct packed {
    logic [VAL_W-1:0] sum;
    logic [VAL_W-1:0] padd;
    logic [VAL_W-1:0] aval;
    logic             avld;
  } node_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_VISIT, ST_CHECK, ST_COV_MUL, ST_COV_WR,
    ST_PL_RD, ST_PL_MUL, ST_PL_WR, ST_MARK_CLR, ST_DESCEND, ST_RETURN,
    ST_PO_RDL, ST_PO_RDR, ST_PO_WR, ST_FINISH
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLEAR, OP_LOAD, OP_RD_SELF, OP_CAP_SELF, OP_COVER_MUL,
    OP_COVER_WR, OP_RD_CHILD, OP_CHILD_MUL, OP_CHILD_WR, OP_MARK_CLR,
    OP_DESCEND, OP_RETURN, OP_PO_RDL, OP_PO_RDR, OP_PO_WR, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   side;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_skip;
    logic outside;
    logic covered;
    logic leafish;
    logic has_mark;
    logic stack_empty;
    logic top_right;
    logic is_query;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> src/rast_if.sv
// Handshake interfaces for the command channel and the result channel.
// Depends on rast_pkg for the field widths.
`default_nettype none

interface rast_in_if import rast_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [POS_W-1:0]        range_start;
  logic [POS_W-1:0]        range_end;
  logic signed [VAL_W-1:0] value;
  modport source (output valid, command, range_start, range_end, value, input ready);
  modport sink (input valid, command, range_start, range_end, value, output ready);
endinterface

interface rast_out_if import rast_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] range_sum;
  modport source (output valid, range_sum, input ready);
  modport sink (input valid, range_sum, output ready);
endinterface

`default_nettype wire

>>> src/rast_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/rast_ctrl.sv
// Controller state machine that walks the tree one node step at a time.
// Depends on rast_pkg for states, commands and status.
`default_nettype none

module rast_ctrl import rast_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   side_r, side_nxt;

  // State and side registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    case (state_r)
      ST_CLEAR:    if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid) state_nxt = stat.in_skip ? ST_IDLE : ST_VISIT;
      ST_VISIT:    state_nxt = stat.outside ? ST_RETURN : ST_CHECK;
      ST_CHECK: begin
        if (stat.covered) begin
          state_nxt = stat.is_query ? ST_RETURN : ST_COV_MUL;
        end else if (stat.leafish) begin
          state_nxt = ST_RETURN;
        end else if (stat.has_mark) begin
          state_nxt = ST_PL_RD;
          side_nxt  = 1'b0;
        end else begin
          state_nxt = ST_DESCEND;
        end
      end
      ST_COV_MUL:  state_nxt = ST_COV_WR;
      ST_COV_WR:   state_nxt = ST_RETURN;
      ST_PL_RD:    state_nxt = ST_PL_MUL;
      ST_PL_MUL:   state_nxt = ST_PL_WR;
      ST_PL_WR: begin
        if (!side_r) begin
          side_nxt  = 1'b1;
          state_nxt = ST_PL_RD;
        end else begin
          state_nxt = ST_MARK_CLR;
        end
      end
      ST_MARK_CLR: state_nxt = ST_DESCEND;
      ST_DESCEND:  state_nxt = ST_VISIT;
      ST_RETURN: begin
        if (stat.stack_empty) state_nxt = ST_FINISH;
        else if (!stat.top_right) state_nxt = ST_VISIT;
        else state_nxt = stat.is_query ? ST_RETURN : ST_PO_RDL;
      end
      ST_PO_RDL:   state_nxt = ST_PO_RDR;
      ST_PO_RDR:   state_nxt = ST_PO_WR;
      ST_PO_WR:    state_nxt = ST_RETURN;
      ST_FINISH:   if (!(stat.is_query && stat.out_busy)) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready = 1'b0;
    cmd.side = side_r;
    cmd.op   = OP_NOP;
    case (state_r)
      ST_CLEAR:    cmd.op = OP_CLEAR;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_VISIT:    cmd.op = OP_RD_SELF;
      ST_CHECK:    cmd.op = OP_CAP_SELF;
      ST_COV_MUL:  cmd.op = OP_COVER_MUL;
      ST_COV_WR:   cmd.op = OP_COVER_WR;
      ST_PL_RD:    cmd.op = OP_RD_CHILD;
      ST_PL_MUL:   cmd.op = OP_CHILD_MUL;
      ST_PL_WR:    cmd.op = OP_CHILD_WR;
      ST_MARK_CLR: cmd.op = OP_MARK_CLR;
      ST_DESCEND:  cmd.op = OP_DESCEND;
      ST_RETURN:   cmd.op = OP_RETURN;
      ST_PO_RDL:   cmd.op = OP_PO_RDL;
      ST_PO_RDR:   cmd.op = OP_PO_RDR;
      ST_PO_WR:    cmd.op = OP_PO_WR;
      ST_FINISH:   cmd.op = OP_FINISH;
      default:     cmd.op = OP_NOP;
    endcase
  end

`ifndef SYNTH
  a_ready_no_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!in_ready && cmd.op == OP_CLEAR))
    else $error("ready raised during clearing pass");
  a_push_two_sides: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PL_WR && !side_r) |=> (state_r == ST_PL_RD && side_r))
    else $error("right child push skipped");
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && !stat.out_busy) |=> (state_r == ST_IDLE))
    else $error("finish did not return to idle");
`endif

endmodule

`default_nettype wire

>>> src/rast_dp.sv
// Datapath: node memory, traversal stack, mark arithmetic, output register.
// Depends on rast_pkg and rast_ram.
`default_nettype none

module rast_dp import rast_pkg::*; #(
  parameter int LEAVES = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dp_cmd_t                 cmd,
  output dp_stat_t                     stat,
  input  wire logic [CMD_W-1:0]        in_command,
  input  wire logic [POS_W-1:0]        in_range_start,
  input  wire logic [POS_W-1:0]        in_range_end,
  input  wire logic [VAL_W-1:0]        in_value,
  input  wire logic                    cfg_we,
  input  wire logic [POS_W-1:0]        cfg_wdata,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [VAL_W-1:0]             out_range_sum
);

  localparam int NODES = 4 * LEAVES;
  localparam int NW    = $clog2(NODES);
  localparam int PW    = $clog2(LEAVES + 1);
  localparam int CW    = (PW > POS_W) ? PW : POS_W;
  localparam int SD    = $clog2(LEAVES) + 2;
  localparam int SIW   = $clog2(SD);
  localparam int SPW   = $clog2(SD + 1);

  logic [POS_W-1:0] len_r;
  logic [CMD_W-1:0] cmd_r;
  logic [POS_W-1:0] s_r, e_r;
  logic [VAL_W-1:0] v_r, acc_r, prod_r, out_sum_r, ch_sum_r;
  logic [NW-1:0]    cur_n_r, clr_r;
  logic [PW-1:0]    cur_lo_r, cur_hi_r;
  logic [NW-1:0]    stk_n [SD];
  logic [PW-1:0]    stk_lo [SD];
  logic [PW-1:0]    stk_hi [SD];
  logic             stk_st [SD];
  logic [SPW-1:0]   sp_r;
  logic             out_valid_r;
  node_t            nd_r, ch_r;

  node_t            rdata, wdata;
  logic             we;
  logic [NW-1:0]    waddr, raddr;

  // Node memory.
  rast_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Range geometry of the current node.
  logic [CW-1:0]  len_c, s_c, e_c, lo_c, hi_c;
  logic [PW-1:0]  mid, cnt_cov, cnt_side;
  logic [NW:0]    left_w, right_w;
  logic [NW-1:0]  left_n, right_n;
  logic [SPW-1:0] sp_m1;
  logic [SIW-1:0] top_i, push_i;
  logic [PW-1:0]  top_mid;

  always_comb begin
    if (len_r == '0) len_c = CW'(1);
    else if (CW'(len_r) > CW'(LEAVES)) len_c = CW'(LEAVES);
    else len_c = CW'(len_r);
    s_c      = CW'(s_r);
    e_c      = CW'(e_r);
    lo_c     = CW'(cur_lo_r);
    hi_c     = CW'(cur_hi_r);
    mid      = cur_lo_r + ((cur_hi_r - cur_lo_r) >> 1);
    cnt_cov  = cur_hi_r - cur_lo_r + PW'(1);
    cnt_side = cmd.side ? (cur_hi_r - mid) : (mid - cur_lo_r + PW'(1));
    left_w   = {cur_n_r, 1'b0};
    right_w  = {cur_n_r, 1'b1};
    left_n   = left_w[NW-1:0];
    right_n  = right_w[NW-1:0];
    sp_m1    = sp_r - SPW'(1);
    top_i    = sp_m1[SIW-1:0];
    push_i   = sp_r[SIW-1:0];
    top_mid  = stk_lo[top_i] + ((stk_hi[top_i] - stk_lo[top_i]) >> 1);
  end

  // Apply an add or assign mark to one node entry.
  function automatic node_t apply_mark(node_t ent, logic [VAL_W-1:0] prod,
                                       logic [VAL_W-1:0] val, logic asg);
    node_t res;
    res = ent;
    if (asg) begin
      res.sum  = prod;
      res.padd = '0;
      res.aval = val;
      res.avld = 1'b1;
    end else begin
      res.sum = ent.sum + prod;
      if (ent.avld) res.aval = ent.aval + val;
      else res.padd = ent.padd + val;
    end
    return res;
  endfunction

  // Multiplier operands: count of positions times the command value or the mark value.
  logic [VAL_W-1:0] mark_val, mul_a;
  logic [PW-1:0]    mul_cnt;
  logic [VAL_W-1:0] mul_p;

  always_comb begin
    mark_val = nd_r.avld ? nd_r.aval : nd_r.padd;
    mul_a    = (cmd.op == OP_COVER_MUL) ? v_r : mark_val;
    mul_cnt  = (cmd.op == OP_COVER_MUL) ? cnt_cov : cnt_side;
    mul_p    = mul_a * VAL_W'(mul_cnt);
  end

  // Memory address and write selection.
  always_comb begin
    we    = 1'b0;
    waddr = cur_n_r;
    wdata = '0;
    raddr = cur_n_r;
    case (cmd.op)
      OP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
      end
      OP_COVER_WR: begin
        we    = 1'b1;
        wdata = apply_mark(nd_r, prod_r, v_r, cmd_r == CMD_ASSIGN);
      end
      OP_RD_CHILD: raddr = cmd.side ? right_n : left_n;
      OP_CHILD_WR: begin
        we    = 1'b1;
        waddr = cmd.side ? right_n : left_n;
        wdata = apply_mark(ch_r, prod_r, mark_val, nd_r.avld);
      end
      OP_MARK_CLR: begin
        we       = 1'b1;
        wdata.sum = nd_r.sum;
      end
      OP_PO_RDL: raddr = left_n;
      OP_PO_RDR: raddr = right_n;
      OP_PO_WR: begin
        we        = 1'b1;
        wdata.sum = ch_sum_r + rdata.sum;
      end
      default: we = 1'b0;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    stat.clr_last    = (clr_r == NW'(NODES - 1));
    stat.in_skip     = (in_command == CMD_NONE);
    stat.outside     = (s_c > hi_c) || (e_c < lo_c);
    stat.covered     = (s_c <= lo_c) && (hi_c <= e_c);
    stat.leafish     = (cur_lo_r >= cur_hi_r) || (right_w >= (NW+1)'(NODES));
    stat.has_mark    = rdata.avld || (rdata.padd != '0);
    stat.stack_empty = (sp_r == '0);
    stat.top_right   = stk_st[top_i];
    stat.is_query    = (cmd_r == CMD_SUM);
    stat.out_busy    = out_valid_r && !out_ready;
  end

  // Control registers: config, clear counter, stack pointer, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_RESET;
      clr_r       <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) len_r <= cfg_wdata;
      if (cmd.op == OP_CLEAR) clr_r <= clr_r + NW'(1);
      // A new result replaces one that leaves in the same cycle.
      if (cmd.op == OP_FINISH && cmd_r == CMD_SUM && !stat.out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD:    sp_r <= '0;
        OP_DESCEND: sp_r <= sp_r + SPW'(1);
        OP_RETURN:  if (sp_r != '0 && stk_st[top_i]) sp_r <= sp_m1;
        default:    sp_r <= sp_r;
      endcase
    end
  end

  // Payload registers and traversal frame.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_r    <= in_command;
        s_r      <= in_range_start;
        e_r      <= in_range_end;
        v_r      <= in_value;
        acc_r    <= '0;
        cur_n_r  <= NW'(1);
        cur_lo_r <= PW'(1);
        cur_hi_r <= len_c[PW-1:0];
      end
      OP_CAP_SELF: begin
        nd_r <= rdata;
        if (cmd_r == CMD_SUM && stat.covered) acc_r <= acc_r + rdata.sum;
      end
      OP_COVER_MUL: prod_r <= mul_p;
      OP_CHILD_MUL: begin
        ch_r   <= rdata;
        prod_r <= mul_p;
      end
      OP_DESCEND: begin
        stk_n[push_i]  <= cur_n_r;
        stk_lo[push_i] <= cur_lo_r;
        stk_hi[push_i] <= cur_hi_r;
        stk_st[push_i] <= 1'b0;
        cur_n_r        <= left_n;
        cur_hi_r       <= mid;
      end
      OP_RETURN: begin
        if (sp_r != '0) begin
          if (!stk_st[top_i]) begin
            stk_st[top_i] <= 1'b1;
            cur_n_r       <= NW'({stk_n[top_i], 1'b1});
            cur_lo_r      <= top_mid + PW'(1);
            cur_hi_r      <= stk_hi[top_i];
          end else begin
            cur_n_r  <= stk_n[top_i];
            cur_lo_r <= stk_lo[top_i];
            cur_hi_r <= stk_hi[top_i];
          end
        end
      end
      OP_PO_RDR: ch_sum_r <= rdata.sum;
      OP_FINISH: if (cmd_r == CMD_SUM && !stat.out_busy) out_sum_r <= acc_r;
      default:   nd_r <= nd_r;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

`ifndef SYNTH
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(SD))
    else $error("traversal stack overflow");
  a_frame_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_RD_SELF) |-> (cur_lo_r <= cur_hi_r && cur_n_r != '0))
    else $error("visited node has an empty range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DESCEND) |=> (sp_r != '0))
    else $error("descend did not push a frame");
`endif

endmodule

`default_nettype wire

>>> src/range_add_set_sum_tree_top.sv
// A command is accepted in idle; each visited node is read, then checked (a node outside
// the range skips the check); each descent pushes a frame that is returned to twice. A
// covered node on an update is multiplied and written; a mark push reads, multiplies and
// writes each child, then clears the mark; a recombine on the way up reads both children
// and writes the sum. One command at a time, set by the single node read port.
// After reset a clearing pass writes all 4*LEAVES nodes with ready low.
`default_nettype none

module range_add_set_sum_tree_top import rast_pkg::*; #(
  parameter int LEAVES = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  rast_in_if.sink               in_ch,
  rast_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic [POS_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     ready;

  // Controller.
  rast_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(ready),
    .stat(stat), .cmd(cmd)
  );

  // Datapath.
  rast_dp #(.LEAVES(LEAVES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_command(in_ch.command), .in_range_start(in_ch.range_start),
    .in_range_end(in_ch.range_end), .in_value(in_ch.value),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_range_sum(out_ch.range_sum)
  );

  assign in_ch.ready = ready;

endmodule

`default_nettype wire

>>> test/tb_range_add_set_sum_tree_top.sv
// Testbench for range_add_set_sum_tree_top: add, assign and sum commands over a lazy sum tree.
// Depends on rast_pkg and the rast_in_if / rast_out_if interfaces from the RTL.
`timescale 1ns / 1ps

module tb_range_add_set_sum_tree_top;
  import rast_pkg::*;

  localparam int TREE_LEAVES = 1024;
  localparam int TREE_NODES  = 4 * TREE_LEAVES;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int DRAIN_WAIT  = 2000;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] last;
    logic [VAL_W-1:0] amount;
  } tree_cmd_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [POS_W-1:0] cfg_wdata;

  rast_in_if  in_if ();
  rast_out_if out_if ();

  range_add_set_sum_tree_top u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the tree kept by the predictor.
  logic [VAL_W-1:0] shadow_sum [TREE_NODES];
  logic [VAL_W-1:0] shadow_add [TREE_NODES];
  logic [VAL_W-1:0] shadow_aval [TREE_NODES];
  logic             shadow_avld [TREE_NODES];
  logic [POS_W-1:0] shadow_len;

  tree_cmd_t        cmd_queue [$];
  logic [VAL_W-1:0] sum_expect [$];
  int               fail_count;
  int               cycle_count;
  logic             cmd_taken;
  int               burst_left;
  int               gap_left;
  int               stall_mode;
  int               stall_timer;

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned tree_span();
    if (shadow_len == 0) return 1;
    if (shadow_len > TREE_LEAVES) return TREE_LEAVES;
    return shadow_len;
  endfunction

  function automatic void mark_assign(int n, longint unsigned cnt, logic [VAL_W-1:0] v);
    shadow_sum[n]  = cnt * v;
    shadow_add[n]  = '0;
    shadow_aval[n] = v;
    shadow_avld[n] = 1'b1;
  endfunction

  function automatic void mark_add(int n, longint unsigned cnt, logic [VAL_W-1:0] v);
    shadow_sum[n] = shadow_sum[n] + cnt * v;
    if (shadow_avld[n]) shadow_aval[n] = shadow_aval[n] + v;
    else shadow_add[n] = shadow_add[n] + v;
  endfunction

  function automatic void push_down(int n, longint unsigned lo, longint unsigned mid,
                                    longint unsigned hi);
    if (2 * n + 1 >= TREE_NODES) return;
    if (shadow_avld[n]) begin
      mark_assign(2 * n, mid - lo + 1, shadow_aval[n]);
      mark_assign(2 * n + 1, hi - mid, shadow_aval[n]);
      shadow_avld[n] = 1'b0;
      shadow_aval[n] = '0;
    end else if (shadow_add[n] != 0) begin
      mark_add(2 * n, mid - lo + 1, shadow_add[n]);
      mark_add(2 * n + 1, hi - mid, shadow_add[n]);
      shadow_add[n] = '0;
    end
  endfunction

  function automatic void tree_update(logic [CMD_W-1:0] op, longint unsigned s,
                                      longint unsigned e, logic [VAL_W-1:0] v, int n,
                                      longint unsigned lo, longint unsigned hi);
    longint unsigned mid;
    if (n >= TREE_NODES || s > hi || e < lo) return;
    if (s <= lo && hi <= e) begin
      if (op == CMD_ADD) mark_add(n, hi - lo + 1, v);
      else mark_assign(n, hi - lo + 1, v);
      return;
    end
    if (lo >= hi || 2 * n + 1 >= TREE_NODES) return;
    mid = lo + ((hi - lo) >> 1);
    push_down(n, lo, mid, hi);
    tree_update(op, s, e, v, 2 * n, lo, mid);
    tree_update(op, s, e, v, 2 * n + 1, mid + 1, hi);
    shadow_sum[n] = shadow_sum[2 * n] + shadow_sum[2 * n + 1];
  endfunction

  function automatic logic [VAL_W-1:0] tree_sum(longint unsigned s, longint unsigned e, int n,
                                                longint unsigned lo, longint unsigned hi);
    longint unsigned mid;
    if (n >= TREE_NODES || s > hi || e < lo) return '0;
    if (s <= lo && hi <= e) return shadow_sum[n];
    if (lo >= hi || 2 * n + 1 >= TREE_NODES) return '0;
    mid = lo + ((hi - lo) >> 1);
    push_down(n, lo, mid, hi);
    return tree_sum(s, e, 2 * n, lo, mid) + tree_sum(s, e, 2 * n + 1, mid + 1, hi);
  endfunction

  // Random operand with a bias toward the extremes and zero.
  function automatic logic [VAL_W-1:0] pick_amount();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '0;
      3: return '1;
      4, 5: return {{$urandom}, {$urandom}};
      default: return 64'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic void queue_cmd(logic [CMD_W-1:0] c, int s, int e, logic [VAL_W-1:0] v);
    tree_cmd_t t;
    t.cmd = c;
    t.first = s[POS_W-1:0];
    t.last = e[POS_W-1:0];
    t.amount = v;
    cmd_queue.push_back(t);
  endfunction

  // One random command, mostly over a well-formed range inside the active length.
  function automatic void queue_random(int len);
    int s;
    int e;
    int pick;
    logic [CMD_W-1:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 30) c = CMD_ADD;
    else if (pick < 58) c = CMD_ASSIGN;
    else if (pick < 97) c = CMD_SUM;
    else c = CMD_NONE;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      s = $urandom_range(1, len);
      e = $urandom_range(s, len);
    end else if (pick < 8) begin
      s = $urandom_range(1, len);
      e = s;
    end else begin
      s = $urandom_range(0, 2047);
      e = $urandom_range(0, 2047);
    end
    queue_cmd(c, s, e, pick_amount());
  endfunction

  // Monitor: checks results and runs the predictor on accepted transactions.
  always @(posedge clk) begin
    cmd_taken = 1'b0;
    if (rst_n) begin
      if (cfg_we) shadow_len = cfg_wdata;
      if (out_if.valid && out_if.ready) begin
        if (sum_expect.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, out_if.range_sum);
          fail_count++;
        end else if (sum_expect[0] !== out_if.range_sum) begin
          $display("%0t: range_sum mismatch, expected %h, actual %h", $time,
                   sum_expect[0], out_if.range_sum);
          fail_count++;
          void'(sum_expect.pop_front());
        end else begin
          void'(sum_expect.pop_front());
        end
      end
      if (in_if.valid && in_if.ready) begin
        cmd_taken = 1'b1;
        if (in_if.command == CMD_ADD || in_if.command == CMD_ASSIGN)
          tree_update(in_if.command, in_if.range_start, in_if.range_end, in_if.value, 1, 1,
                      tree_span());
        else if (in_if.command == CMD_SUM)
          sum_expect.push_back(tree_sum(in_if.range_start, in_if.range_end, 1, 1,
                                        tree_span()));
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_range_add_set_sum_tree_top: FAIL");
      $finish;
    end
  end

  // Driver: sends queued commands in bursts separated by random gaps.
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || cmd_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.command <= cmd_queue[0].cmd;
        in_if.range_start <= cmd_queue[0].first;
        in_if.range_end <= cmd_queue[0].last;
        in_if.value <= cmd_queue[0].amount;
        void'(cmd_queue.pop_front());
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: picks a new random stall pattern whenever its timer runs out.
  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_timer = $urandom_range(50, 400);
      stall_mode = $urandom_range(0, 3);
    end else begin
      stall_timer--;
    end
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= $urandom_range(0, 1);
      2: out_if.ready <= ($urandom_range(0, 7) == 0);
      default: out_if.ready <= ($urandom_range(0, 20) != 0);
    endcase
  end

  task automatic wait_quiet();
    while (cmd_queue.size() > 0 || in_if.valid || sum_expect.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_length(logic [POS_W-1:0] len);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus: directed commands, then random phases at several lengths.
  initial begin
    logic [POS_W-1:0] lengths [9];
    int span;
    lengths = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd5, 11'd37, 11'd512, 11'd1000, 11'd3};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.command = CMD_ADD;
    in_if.range_start = '0;
    in_if.range_end = '0;
    in_if.value = '0;
    out_if.ready = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = 0;
    stall_timer = 0;
    cmd_taken = 1'b0;
    shadow_len = LEN_RESET;
    for (int i = 0; i < TREE_NODES; i++) begin
      shadow_sum[i] = '0;
      shadow_add[i] = '0;
      shadow_aval[i] = '0;
      shadow_avld[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed commands: extremes, empty and partly outside ranges, zero assign.
    queue_cmd(CMD_SUM, 1, 1024, '0);
    queue_cmd(CMD_ADD, 1, 1024, 64'h7fff_ffff_ffff_ffff);
    queue_cmd(CMD_SUM, 1, 1024, '0);
    queue_cmd(CMD_ADD, 1, 512, 64'h8000_0000_0000_0000);
    queue_cmd(CMD_SUM, 500, 600, '0);
    queue_cmd(CMD_ASSIGN, 3, 3, 64'd42);
    queue_cmd(CMD_ASSIGN, 4, 4, 64'hffff_ffff_ffff_fffe);
    queue_cmd(CMD_SUM, 2, 5, '0);
    queue_cmd(CMD_ASSIGN, 1, 1024, '0);
    queue_cmd(CMD_SUM, 1, 1024, '0);
    queue_cmd(CMD_ADD, 10, 20, 64'd7);
    queue_cmd(CMD_ASSIGN, 15, 30, '0);
    queue_cmd(CMD_SUM, 1, 1024, '0);
    queue_cmd(CMD_SUM, 20, 10, '0);
    queue_cmd(CMD_ADD, 900, 800, 64'd5);
    queue_cmd(CMD_ADD, 1000, 2047, 64'd3);
    queue_cmd(CMD_SUM, 0, 2047, '0);
    queue_cmd(CMD_SUM, 1025, 2047, '0);
    queue_cmd(CMD_NONE, 1, 1024, 64'd99);
    queue_cmd(CMD_SUM, 1024, 1024, '0);
    queue_cmd(CMD_SUM, 1, 1, '0);
    queue_cmd(CMD_ASSIGN, 0, 0, 64'd11);
    queue_cmd(CMD_SUM, 0, 1, '0);
    wait_quiet();

    // Random phases; the sender pauses between them until all results are in.
    foreach (lengths[p]) begin
      write_length(lengths[p]);
      span = (lengths[p] == 0) ? 1 : (lengths[p] > TREE_LEAVES) ? TREE_LEAVES : lengths[p];
      // Load some positions one by one, then mixed random commands.
      for (int i = 0; i < 12 && i < span; i++)
        queue_cmd(CMD_ASSIGN, $urandom_range(1, span), 0, pick_amount());
      foreach (cmd_queue[k])
        if (cmd_queue[k].last == 0) cmd_queue[k].last = cmd_queue[k].first;
      for (int i = 0; i < 145; i++) queue_random(span);
      wait_quiet();
    end

    if (fail_count == 0) $display("tb_range_add_set_sum_tree_top: PASS");
    else $display("tb_range_add_set_sum_tree_top: FAIL");
    $finish;
  end

endmodule
